// ===== src/url_percent_decoder_core_macros.svh =====
// assertion macros shared by the url percent decoder modules
`ifndef URL_PERCENT_DECODER_CORE_MACROS_SVH
`define URL_PERCENT_DECODER_CORE_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define UPD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("upd assertion failed");
// condition must never be seen outside reset
`define UPD_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("upd forbidden condition seen");
`else
`define UPD_ASSERT(lbl, clk, rst, prop)
`define UPD_NEVER(lbl, clk, rst, cond)
`endif

`endif

// ===== src/upd_pkg.sv =====
// types, constants and helpers of the url percent decoder
package upd_pkg;

   localparam int unsigned MAX_OUT     = 3;
   localparam int unsigned CNT_W       = $clog2(MAX_OUT + 1);
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PERCENT = 8'h25;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PERCENT = 2'd1,
      PH_DIGIT   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [MAX_OUT-1:0][7:0] bytes;
      logic [CNT_W-1:0]        count;
      logic                    last;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] nib;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type r;
      r.ok  = 1'b1;
      r.nib = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.nib = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.nib = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.nib = 4'(c - 8'h37);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== src/upd_if.sv =====
// stream interfaces for raw and decoded bytes
interface upd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== src/upd_front.sv =====
// front end: accepts raw bytes, tracks escape phase, builds result groups
module upd_front (
   input  logic                      clock,
   input  logic                      reset,
   upd_req_if.sink                   req_chan,
   input  upd_pkg::queue_status_type qstat,
   output logic                      push,
   output upd_pkg::entry_type        entry
);

   upd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         held_ff, held_in;

   upd_pkg::hex_type           hb;
   upd_pkg::hex_type           hh;
   logic [upd_pkg::CNT_W-1:0]  n;
   logic                       normal;
   logic                       accept;

   assign req_chan.ready = !qstat.full;
   assign accept         = req_chan.valid && !qstat.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= upd_pkg::PH_IDLE;
         held_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   always_comb begin
      hb          = upd_pkg::hex_decode(req_chan.in_byte);
      hh          = upd_pkg::hex_decode(held_ff);
      phase_in    = phase_ff;
      held_in     = held_ff;
      n           = '0;
      normal      = 1'b1;
      entry.bytes = '0;
      entry.last  = req_chan.in_last;

      unique case (phase_ff)
         upd_pkg::PH_PERCENT: begin
            if (hb.ok) begin
               held_in  = req_chan.in_byte;
               phase_in = upd_pkg::PH_DIGIT;
               normal   = 1'b0;
            end else begin
               entry.bytes[n] = upd_pkg::CH_PERCENT;
               n              = n + upd_pkg::CNT_W'(1);
               phase_in       = upd_pkg::PH_IDLE;
            end
         end
         upd_pkg::PH_DIGIT: begin
            if (hb.ok) begin
               // held digit is always hex here, so hh.nib is valid
               entry.bytes[n] = {hh.nib, hb.nib};
               n              = n + upd_pkg::CNT_W'(1);
               phase_in       = upd_pkg::PH_IDLE;
               normal         = 1'b0;
            end else begin
               entry.bytes[n] = upd_pkg::CH_PERCENT;
               n              = n + upd_pkg::CNT_W'(1);
               entry.bytes[n] = held_ff;
               n              = n + upd_pkg::CNT_W'(1);
               phase_in       = upd_pkg::PH_IDLE;
            end
         end
         default: begin
            // idle, and the unused phase code treated as idle
            phase_in = upd_pkg::PH_IDLE;
         end
      endcase

      if (normal) begin
         if (req_chan.in_byte == upd_pkg::CH_PLUS) begin
            entry.bytes[n] = upd_pkg::CH_SPACE;
            n              = n + upd_pkg::CNT_W'(1);
         end else if (req_chan.in_byte == upd_pkg::CH_PERCENT) begin
            phase_in = upd_pkg::PH_PERCENT;
         end else begin
            entry.bytes[n] = req_chan.in_byte;
            n              = n + upd_pkg::CNT_W'(1);
         end
      end

      // end of string: flush a pending escape literally
      if (req_chan.in_last) begin
         if (phase_in == upd_pkg::PH_PERCENT) begin
            entry.bytes[n] = upd_pkg::CH_PERCENT;
            n              = n + upd_pkg::CNT_W'(1);
         end else if (phase_in == upd_pkg::PH_DIGIT) begin
            entry.bytes[n] = upd_pkg::CH_PERCENT;
            n              = n + upd_pkg::CNT_W'(1);
            entry.bytes[n] = held_in;
            n              = n + upd_pkg::CNT_W'(1);
         end
         phase_in = upd_pkg::PH_IDLE;
      end

      if (phase_in == upd_pkg::PH_IDLE) begin
         held_in = 8'd0;
      end

      entry.count = n;

      if (!accept) begin
         phase_in = phase_ff;
         held_in  = held_ff;
      end
   end

   assign push = accept && (n != '0);

endmodule

// ===== src/upd_queue.sv =====
// short queue of result groups between front and back
module upd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  upd_pkg::entry_type        push_entry,
   input  logic                      pop,
   output upd_pkg::entry_type        head,
   output upd_pkg::queue_status_type qstat
);

`include "url_percent_decoder_core_macros.svh"

   upd_pkg::entry_type           slot_ff [upd_pkg::QUEUE_DEPTH];
   logic [upd_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [upd_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [upd_pkg::QCNT_W-1:0]   cnt_ff, cnt_in;

   function automatic logic [upd_pkg::QPTR_W-1:0] ptr_next(
      input logic [upd_pkg::QPTR_W-1:0] p
   );
      logic [upd_pkg::QPTR_W-1:0] r;
      if (p == upd_pkg::QPTR_W'(upd_pkg::QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + upd_pkg::QPTR_W'(1);
      end
      return r;
   endfunction

   assign qstat.empty = (cnt_ff == '0);
   assign qstat.full  = (cnt_ff == upd_pkg::QCNT_W'(upd_pkg::QUEUE_DEPTH));
   assign head        = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + upd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - upd_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `UPD_NEVER(a_no_push_when_full, clock, reset, push && qstat.full)
   `UPD_NEVER(a_no_pop_when_empty, clock, reset, pop && qstat.empty)
   `UPD_ASSERT(a_cnt_bounded, clock, reset, cnt_ff <= upd_pkg::QCNT_W'(upd_pkg::QUEUE_DEPTH))

endmodule

// ===== src/upd_back.sv =====
// back end: takes result groups apart into one output byte per transaction
module upd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  upd_pkg::entry_type        head,
   input  upd_pkg::queue_status_type qstat,
   output logic                      pop,
   upd_rsp_if.source                 rsp_chan
);

`include "url_percent_decoder_core_macros.svh"

   upd_pkg::entry_type         cur_ff, cur_in;
   logic [upd_pkg::CNT_W-1:0]  pos_ff, pos_in;
   logic                       hold_valid_ff, hold_valid_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 out_byte_ff, out_byte_in;
   logic                       out_last_ff, out_last_in;
   logic                       load;

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = out_byte_ff;
   assign rsp_chan.out_last = out_last_ff;

   // output register may take a new byte when empty or being drained
   assign load = !rsp_valid_ff || rsp_chan.ready;
   assign pop  = load && !hold_valid_ff && !qstat.empty;

   always_comb begin
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      hold_valid_in = hold_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      if (load) begin
         if (hold_valid_ff) begin
            out_byte_in   = cur_ff.bytes[pos_ff];
            out_last_in   = cur_ff.last && (pos_ff + upd_pkg::CNT_W'(1) == cur_ff.count);
            pos_in        = pos_ff + upd_pkg::CNT_W'(1);
            hold_valid_in = (pos_ff + upd_pkg::CNT_W'(1) != cur_ff.count);
            rsp_valid_in  = 1'b1;
         end else if (!qstat.empty) begin
            cur_in        = head;
            out_byte_in   = head.bytes[0];
            out_last_in   = head.last && (head.count == upd_pkg::CNT_W'(1));
            pos_in        = upd_pkg::CNT_W'(1);
            hold_valid_in = (head.count != upd_pkg::CNT_W'(1));
            rsp_valid_in  = 1'b1;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pos_ff        <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pos_ff        <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   `UPD_NEVER(a_no_pop_while_holding, clock, reset, pop && hold_valid_ff)
   `UPD_ASSERT(a_hold_pos_in_range, clock, reset, !hold_valid_ff || (pos_ff != '0 && pos_ff < cur_ff.count))
   `UPD_NEVER(a_last_ends_group, clock, reset, rsp_valid_ff && out_last_ff && hold_valid_ff)

endmodule

// ===== src/url_percent_decoder_core.sv =====
// top level of the streaming url percent decoder
//
//   channel   dir   handshake             payload
//   req_chan  in    valid / ready         in_byte[7:0], in_last
//   rsp_chan  out   valid / ready         out_byte[7:0], out_last
//
// one raw byte is taken per cycle while the group queue has room
// a raw byte yields zero to three decoded bytes; the back end sends one per cycle while
// rsp_chan.ready holds, so a byte that yields n results takes n output transfers
// a decoded byte passes through the group queue and then the output register
// synchronous active-high reset clears the escape phase, queue and output valid bit
// a stalled output fills the queue, after which req_chan.ready drops
module url_percent_decoder_core (
   input  logic      clock,
   input  logic      reset,
   upd_req_if.sink   req_chan,
   upd_rsp_if.source rsp_chan
);

   upd_pkg::queue_status_type qstat;
   upd_pkg::entry_type        push_entry;
   upd_pkg::entry_type        head;
   logic                      push;
   logic                      pop;

   upd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .qstat    (qstat),
      .push     (push),
      .entry    (push_entry)
   );

   upd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   upd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .qstat    (qstat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
